// File: design/quantized_row_dot_product_assert.svh
// Assertion macros for the design files; the controller uses them.
`ifndef QUANTIZED_ROW_DOT_PRODUCT_ASSERT_SVH
`define QUANTIZED_ROW_DOT_PRODUCT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define QRDP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define QRDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QRDP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define QRDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/qrdp_pkg.sv
package qrdp_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned ACT_IDX_W   = 12;
  localparam int unsigned ACT_VAL_W   = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SCALE_W     = 32;
  localparam int unsigned ROW_LEN_W   = 13;
  localparam int unsigned DOT_W       = 29;
  localparam int unsigned SCALED_W    = 60;
  localparam int unsigned ROW_IDX_W   = 16;

  // Internal arithmetic widths.
  localparam int unsigned ACC_W       = 28;
  localparam int unsigned MAG_W       = 28;
  localparam int unsigned PSCALE_W    = 2 * SCALE_W;
  localparam int unsigned PROD_W      = MAG_W + PSCALE_W;
  localparam int unsigned PART_W      = MAG_W + SCALE_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_SCALE     = 2'd2;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST = 13'd4096;
  localparam logic [SCALE_W-1:0]   ACT_SCALE_RST  = 32'd16777216;

  // Request type and weight format codes.
  localparam logic REQ_ACT    = 1'b0;
  localparam logic REQ_WEIGHT = 1'b1;
  localparam logic FMT_INT8   = 1'b0;
  localparam logic FMT_INT4   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_act;   // capture an activation request, start index reduction
    logic load_wt;    // capture a weight request, launch the store reads
    logic red_step;   // one compare-subtract step of the index reduction
    logic act_write;  // write the activation into its bank
    logic mul_prod;   // form the two weight products
    logic acc_add;    // accumulate the products
    logic mul_p;      // multiply the two scales
    logic mul_lo;     // magnitude times low half of the scale product
    logic mul_hi;     // add magnitude times high half
    logic out_load;   // round, saturate and load the output register
  } qrdp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic red_last;   // the current reduction step is the last one
    logic row_end;    // the weight request in flight ends the row
  } qrdp_sts_t;

endpackage

// File: design/qrdp_if.sv
interface qrdp_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [qrdp_pkg::ACT_IDX_W-1:0] act_index;
  logic signed [qrdp_pkg::ACT_VAL_W-1:0] act_value;
  logic [qrdp_pkg::BYTE_W-1:0]    weight_byte;
  logic [qrdp_pkg::SCALE_W-1:0]   row_scale;

  modport source (
    output valid, req_type, act_index, act_value, weight_byte, row_scale,
    input  ready
  );
  modport sink (
    input  valid, req_type, act_index, act_value, weight_byte, row_scale,
    output ready
  );
endinterface

interface qrdp_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrdp_pkg::DOT_W-1:0]    row_dot;
  logic signed [qrdp_pkg::SCALED_W-1:0] scaled_value;
  logic [qrdp_pkg::ROW_IDX_W-1:0]       row_index;

  modport source (
    output valid, row_dot, scaled_value, row_index,
    input  ready
  );
  modport sink (
    input  valid, row_dot, scaled_value, row_index,
    output ready
  );
endinterface

// File: design/qrdp_ram.sv
module qrdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/qrdp_ctrl.sv
`include "quantized_row_dot_product_assert.svh"

module qrdp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_type_i,
  output logic                req_ready_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  input  qrdp_pkg::qrdp_sts_t sts_i,
  output qrdp_pkg::qrdp_cmd_t cmd_o
);
  import qrdp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RED   = 9'b000000010,
    S_WR    = 9'b000000100,
    S_RD    = 9'b000001000,
    S_ACC   = 9'b000010000,
    S_MULP  = 9'b000100000,
    S_MULLO = 9'b001000000,
    S_MULHI = 9'b010000000,
    S_FIN   = 9'b100000000
  } qrdp_state_e;

  qrdp_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  qrdp_cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_type_i == REQ_WEIGHT) begin
            cmd.load_wt = 1'b1;
            state_d     = S_RD;
          end else begin
            cmd.load_act = 1'b1;
            state_d      = S_RED;
          end
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        if (sts_i.red_last) begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        cmd.act_write = 1'b1;
        state_d       = S_IDLE;
      end
      S_RD: begin
        cmd.mul_prod = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_d     = sts_i.row_end ? S_MULP : S_IDLE;
      end
      S_MULP: begin
        cmd.mul_p = 1'b1;
        state_d   = S_MULLO;
      end
      S_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_d    = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        // Wait here while the previous result has not been taken.
        if (!out_valid_q || res_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `QRDP_ASSERT_IMPL(a_load_free, clk_i, rst_ni, cmd.out_load, !out_valid_q || res_ready_i)
  `QRDP_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd.out_load, out_valid_q)
  `QRDP_ASSERT_NEXT(a_wt_to_rd, clk_i, rst_ni, cmd.load_wt, state_q == S_RD)
  `QRDP_ASSERT_NEXT(a_end_scales, clk_i, rst_ni, (state_q == S_ACC) && sts_i.row_end, state_q == S_MULP)

endmodule

// File: design/qrdp_dp.sv
module qrdp_dp #(
  parameter int unsigned MAX_COLS        = 4096,
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [qrdp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qrdp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [qrdp_pkg::ACT_IDX_W-1:0]       act_index_i,
  input  logic signed [qrdp_pkg::ACT_VAL_W-1:0] act_value_i,
  input  logic [qrdp_pkg::BYTE_W-1:0]          weight_byte_i,
  input  logic [qrdp_pkg::SCALE_W-1:0]         row_scale_i,
  input  qrdp_pkg::qrdp_cmd_t                  cmd_i,
  output qrdp_pkg::qrdp_sts_t                  sts_o,
  output logic signed [qrdp_pkg::DOT_W-1:0]    row_dot_o,
  output logic signed [qrdp_pkg::SCALED_W-1:0] scaled_value_o,
  output logic [qrdp_pkg::ROW_IDX_W-1:0]       row_index_o
);
  import qrdp_pkg::*;

  localparam int unsigned CW         = $clog2(MAX_COLS);
  localparam int unsigned PW         = CW + 1;
  localparam int unsigned BANK_DEPTH = (MAX_COLS + 1) / 2;
  localparam int unsigned BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned RED_STEPS  = (CW >= ACT_IDX_W + 1) ? 1 : ACT_IDX_W + 1 - CW;
  localparam int unsigned KW         = $clog2(RED_STEPS + 1);
  localparam int unsigned CMPW       = CW + 1 + RED_STEPS;
  localparam int unsigned SHIFT      = 2 * SCALE_FRAC_BITS - 16;
  localparam logic [PROD_W-1:0] LIM_P    = PROD_W'(1) << (SCALED_W - 1);
  localparam logic [PROD_W-1:0] REM_MASK = (PROD_W'(1) << SHIFT) - PROD_W'(1);

  // Configuration registers.
  logic                 fmt_q;
  logic [ROW_LEN_W-1:0] rl_q;
  logic [SCALE_W-1:0]   as_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_INT8;
      rl_q  <= ROW_LENGTH_RST;
      as_q  <= ACT_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WEIGHT_FORMAT: fmt_q <= cfg_data_i[0];
        CFG_ROW_LENGTH:    rl_q  <= cfg_data_i[ROW_LEN_W-1:0];
        CFG_ACT_SCALE:     as_q  <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row length, clamped to one through MAX_COLS.
  logic [PW-1:0] len;

  always_comb begin
    if (rl_q == '0) begin
      len = PW'(1);
    end else if (32'(rl_q) > 32'(MAX_COLS)) begin
      len = PW'(MAX_COLS);
    end else begin
      len = PW'(rl_q);
    end
  end

  // Column tracking and store read addresses.
  logic [CW-1:0]  pos_q;
  logic [PW-1:0]  pos_ext, next_pos;
  logic           use_hi, row_end;
  logic [BAW-1:0] half, even_raddr;

  assign pos_ext    = PW'(pos_q);
  assign use_hi     = (fmt_q == FMT_INT4) && ((pos_ext + PW'(1)) < len);
  assign next_pos   = pos_ext + (use_hi ? PW'(2) : PW'(1));
  assign row_end    = (next_pos >= len);
  assign half       = BAW'(pos_q >> 1);
  assign even_raddr = (pos_q[0] && use_hi) ? half + BAW'(1) : half;

  logic [BYTE_W-1:0]  byte_q;
  logic [SCALE_W-1:0] rs_q;
  logic               wfmt_q, use_hi_q, odd_q, row_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.load_wt) begin
      pos_q <= row_end ? '0 : CW'(next_pos);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wt) begin
      byte_q    <= weight_byte_i;
      rs_q      <= row_scale_i;
      wfmt_q    <= fmt_q;
      use_hi_q  <= use_hi;
      odd_q     <= pos_q[0];
      row_end_q <= row_end;
    end
  end

  // Activation index reduction modulo MAX_COLS, one compare-subtract a cycle.
  logic [ACT_IDX_W-1:0] red_q;
  logic [KW-1:0]        k_q;
  logic [CMPW-1:0]      red_cmp;
  logic [ACT_VAL_W-1:0] val_q;

  assign red_cmp = CMPW'(MAX_COLS) << k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_act) begin
      red_q <= act_index_i;
      k_q   <= KW'(RED_STEPS - 1);
      val_q <= act_value_i;
    end else if (cmd_i.red_step) begin
      if (CMPW'(red_q) >= red_cmp) begin
        red_q <= red_q - ACT_IDX_W'(red_cmp);
      end
      if (k_q != '0) begin
        k_q <= k_q - KW'(1);
      end
    end
  end

  assign sts_o.red_last = (k_q == '0);
  assign sts_o.row_end  = row_end_q;

  // Two banks hold even and odd columns, so two neighbors are read in the same cycle.
  logic [CW-1:0]     wr_col;
  logic [BAW-1:0]    wr_addr;
  logic              even_we, odd_we;
  logic [BYTE_W-1:0] even_rd, odd_rd;

  assign wr_col  = CW'(red_q);
  assign wr_addr = BAW'(wr_col >> 1);
  assign even_we = cmd_i.act_write && !wr_col[0];
  assign odd_we  = cmd_i.act_write && wr_col[0];

  qrdp_ram #(
    .WIDTH (ACT_VAL_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (wr_addr),
    .wdata_i (val_q),
    .re_i    (cmd_i.load_wt),
    .raddr_i (even_raddr),
    .rdata_o (even_rd)
  );

  qrdp_ram #(
    .WIDTH (ACT_VAL_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (wr_addr),
    .wdata_i (val_q),
    .re_i    (cmd_i.load_wt),
    .raddr_i (half),
    .rdata_o (odd_rd)
  );

  // Weight decode and products.
  logic signed [7:0]  a0, a1, w0, w1;
  logic signed [15:0] p0, p1, p0_q, p1_q;

  assign a0 = $signed(odd_q ? odd_rd : even_rd);
  assign a1 = $signed(odd_q ? even_rd : odd_rd);
  assign w0 = (wfmt_q == FMT_INT4) ? $signed({{5{~byte_q[3]}}, byte_q[2:0]})
                                   : $signed(byte_q);
  assign w1 = use_hi_q ? $signed({{5{~byte_q[7]}}, byte_q[6:4]}) : 8'sd0;
  assign p0 = 16'(a0) * 16'(w0);
  assign p1 = 16'(a1) * 16'(w1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_prod) begin
      p0_q <= p0;
      p1_q <= p1;
    end
  end

  // Accumulator.
  logic signed [ACC_W-1:0] acc_q, acc_sum;
  logic signed [DOT_W-1:0] dot_q;

  assign acc_sum = acc_q + ACC_W'(p0_q) + ACC_W'(p1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= row_end_q ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_add && row_end_q) begin
      dot_q <= DOT_W'(acc_sum);
    end
  end

  // Scaling: magnitude times the 64-bit scale product in two halves.
  logic [PSCALE_W-1:0] p_q;
  logic [MAG_W-1:0]    mag_q;
  logic                neg_q;
  logic [PART_W-1:0]   lo_mul, hi_mul;
  logic [PROD_W-1:0]   prod_q, qfull;
  logic [SCALED_W-1:0] q60, scaled;
  logic                sat, rem;

  assign lo_mul = PART_W'(mag_q) * PART_W'(p_q[SCALE_W-1:0]);
  assign hi_mul = PART_W'(mag_q) * PART_W'(p_q[PSCALE_W-1:SCALE_W]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_p) begin
      p_q   <= PSCALE_W'(as_q) * PSCALE_W'(rs_q);
      mag_q <= MAG_W'(dot_q[DOT_W-1] ? -dot_q : dot_q);
      neg_q <= dot_q[DOT_W-1];
    end
    if (cmd_i.mul_lo) begin
      prod_q <= PROD_W'(lo_mul);
    end else if (cmd_i.mul_hi) begin
      prod_q <= prod_q + (PROD_W'(hi_mul) << SCALE_W);
    end
  end

  // Floor shift for both signs: a negative result rounds away from zero
  // when any dropped bit is set, which folds into the negation.
  assign qfull = prod_q >> SHIFT;
  assign q60   = qfull[SCALED_W-1:0];
  assign sat   = (qfull >= LIM_P);
  assign rem   = |(prod_q & REM_MASK);

  always_comb begin
    if (!neg_q) begin
      scaled = sat ? {1'b0, {(SCALED_W-1){1'b1}}} : q60;
    end else begin
      scaled = sat ? {1'b1, {(SCALED_W-1){1'b0}}} : (~q60 + SCALED_W'(!rem));
    end
  end

  // Output register and row counter.
  logic signed [DOT_W-1:0]    out_dot_q;
  logic signed [SCALED_W-1:0] out_scaled_q;
  logic [ROW_IDX_W-1:0]       out_row_q, row_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else if (cmd_i.out_load) begin
      row_cnt_q <= row_cnt_q + ROW_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_dot_q    <= dot_q;
      out_scaled_q <= $signed(scaled);
      out_row_q    <= row_cnt_q;
    end
  end

  assign row_dot_o      = out_dot_q;
  assign scaled_value_o = out_scaled_q;
  assign row_index_o    = out_row_q;

endmodule

// File: design/quantized_row_dot_product.sv
// Quantized row dot-product engine: int8 activations against int8 or int4 weights.
// Request channel (req_i): an activation request (req_type 0) stores act_value at
// column act_index modulo MAX_COLS; a weight request (req_type 1) feeds one byte of
// the current row, one int8 weight or two int4 weights with the low nibble first.
// Result channel (res_o): one result per completed row with the exact dot product,
// the Q.16 scaled value and a wrapping row count.
// Configuration: write weight_format, row_length or act_scale through cfg_we_i,
// cfg_idx_i and cfg_data_i while no request is in progress.
// Sequencing: a weight byte that does not end a row passes through the registered
// store read, the product stage and the accumulate stage. An activation request
// passes through RED_STEPS compare-subtract steps that reduce the index and then
// a store write. The engine takes no new request before it is through with the
// last one. A byte that ends a row then goes through three multiply steps for the
// two scales and one round-and-saturate step, which waits while the output
// register still holds a result that has not been taken.
// Reset clears the column position, accumulator, row count and configuration;
// activation store contents are undefined until written.
// When the receiver stalls, the result holds in the output register while the
// engine keeps taking requests; a further row end waits until that slot frees.
module quantized_row_dot_product #(
  parameter int unsigned MAX_COLS        = 4096,
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qrdp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [qrdp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  qrdp_req_if.sink                        req_i,
  qrdp_res_if.source                      res_o
);
  import qrdp_pkg::*;

  // Command and status bundles between the controller and the datapath.
  qrdp_cmd_t cmd;
  qrdp_sts_t sts;

  // The controller owns sequencing and both handshakes.
  qrdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the banked activation store, the
  // accumulator, the scaling multiplier and the output register.
  qrdp_dp #(
    .MAX_COLS        (MAX_COLS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .act_index_i    (req_i.act_index),
    .act_value_i    (req_i.act_value),
    .weight_byte_i  (req_i.weight_byte),
    .row_scale_i    (req_i.row_scale),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .row_dot_o      (res_o.row_dot),
    .scaled_value_o (res_o.scaled_value),
    .row_index_o    (res_o.row_index)
  );

endmodule

// File: verif/qrdp_row_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register ports of the dot-product engine,
// keeps its own copy of the engine state and checks every result in order.
module qrdp_row_checker
  import qrdp_pkg::*;
#(
  parameter int unsigned MAX_COLS        = 4096,
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  qrdp_req_if                   req_mon_i,
  qrdp_res_if                   res_mon_i,
  output int unsigned           fail_cnt_o,
  output int unsigned           pending_o,
  output int unsigned           rows_o
);

  localparam int unsigned SCALE_SHIFT   = 2 * SCALE_FRAC_BITS - 16;
  localparam int          NIBBLE_OFFSET = 8;

  typedef struct {
    logic signed [DOT_W-1:0]    dot;
    logic signed [SCALED_W-1:0] scaled;
    logic [ROW_IDX_W-1:0]       idx;
  } row_result_t;

  logic                       fmt_q;
  logic [ROW_LEN_W-1:0]       row_len_q;
  logic [SCALE_W-1:0]         act_scale_q;
  logic signed [ACT_VAL_W-1:0] act_mem [MAX_COLS];
  int unsigned                col_pos_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [ROW_IDX_W-1:0]       row_cnt_q;
  row_result_t                expected_rows [$];

  // Dot times both scales, floor shifted to Q.16 and saturated to the result width.
  function automatic logic signed [SCALED_W-1:0] scale_dot(logic signed [ACC_W-1:0] dot,
                                                           logic [SCALE_W-1:0] rs);
    logic signed [127:0] prod;
    logic signed [127:0] sat_hi;
    logic signed [127:0] sat_lo;
    sat_hi = (128'sd1 <<< (SCALED_W - 1)) - 128'sd1;
    sat_lo = -(128'sd1 <<< (SCALED_W - 1));
    prod = dot;
    prod = prod * $signed({96'd0, act_scale_q}) * $signed({96'd0, rs});
    prod = prod >>> SCALE_SHIFT;
    if (prod > sat_hi) begin
      prod = sat_hi;
    end else if (prod < sat_lo) begin
      prod = sat_lo;
    end
    return prod[SCALED_W-1:0];
  endfunction

  function automatic void take_weight_byte(logic [BYTE_W-1:0] wb, logic [SCALE_W-1:0] rs);
    int unsigned len;
    int unsigned pos;
    row_result_t want;
    len = row_len_q;
    if (len < 1) len = 1;
    if (len > MAX_COLS) len = MAX_COLS;
    pos = col_pos_q % MAX_COLS;
    if (fmt_q == FMT_INT8) begin
      acc_q += int'(act_mem[pos]) * int'($signed(wb));
      pos++;
    end else begin
      acc_q += int'(act_mem[pos]) * (int'(wb[3:0]) - NIBBLE_OFFSET);
      // On the last column of an odd row the high nibble is dropped.
      if (pos + 1 < len) begin
        acc_q += int'(act_mem[pos + 1]) * (int'(wb[7:4]) - NIBBLE_OFFSET);
        pos += 2;
      end else begin
        pos++;
      end
    end
    if (pos < len) begin
      col_pos_q = pos;
      return;
    end
    want.dot    = acc_q;
    want.scaled = scale_dot(acc_q, rs);
    want.idx    = row_cnt_q;
    expected_rows.push_back(want);
    row_cnt_q++;
    acc_q     = '0;
    col_pos_q = 0;
  endfunction

  function automatic void check_row_result();
    row_result_t want;
    if (expected_rows.size() == 0) begin
      $display("%0t: result with no row pending: row_dot %0d scaled %0d row_index %0d",
               $time, res_mon_i.row_dot, res_mon_i.scaled_value, res_mon_i.row_index);
      fail_cnt_o++;
      return;
    end
    want = expected_rows.pop_front();
    if (res_mon_i.row_dot !== want.dot) begin
      $display("%0t: row %0d row_dot mismatch: expected %0d, got %0d",
               $time, want.idx, want.dot, res_mon_i.row_dot);
      fail_cnt_o++;
    end
    if (res_mon_i.scaled_value !== want.scaled) begin
      $display("%0t: row %0d scaled_value mismatch: expected %0d, got %0d",
               $time, want.idx, want.scaled, res_mon_i.scaled_value);
      fail_cnt_o++;
    end
    if (res_mon_i.row_index !== want.idx) begin
      $display("%0t: row_index mismatch: expected %0d, got %0d",
               $time, want.idx, res_mon_i.row_index);
      fail_cnt_o++;
    end
  endfunction

  // Requests accepted at an edge still see the old registers; a register write
  // at the same edge takes effect afterwards.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       = FMT_INT8;
      row_len_q   = ROW_LENGTH_RST;
      act_scale_q = ACT_SCALE_RST;
      col_pos_q   = 0;
      acc_q       = '0;
      row_cnt_q   = '0;
      expected_rows.delete();
    end else begin
      if (res_mon_i.valid && res_mon_i.ready) begin
        check_row_result();
        rows_o++;
      end
      if (req_mon_i.valid && req_mon_i.ready) begin
        if (req_mon_i.req_type == REQ_ACT) begin
          act_mem[req_mon_i.act_index % MAX_COLS] = req_mon_i.act_value;
        end else begin
          take_weight_byte(req_mon_i.weight_byte, req_mon_i.row_scale);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WEIGHT_FORMAT: fmt_q       = cfg_data_i[0];
          CFG_ROW_LENGTH:    row_len_q   = cfg_data_i[ROW_LEN_W-1:0];
          CFG_ACT_SCALE:     act_scale_q = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_rows.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

// Top of the testbench for the quantized row dot-product engine. This module
// only makes stimulus and gives the verdict; the checker beside the engine
// predicts every row result and compares it.
module tb_top;
  import qrdp_pkg::*;

  localparam int unsigned MAX_COLS        = 4096;
  localparam int unsigned SCALE_FRAC_BITS = 24;

  // The quiet pause after the last result lets the engine retire a byte that did
  // not end a row before a register write or the verdict.
  localparam int unsigned SETTLE_CYCLES = 12;
  // The longest correct gap without any handshake is a settle pause plus a run
  // of receiver stalls; this limit is far above it.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_REQUESTS = 84;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  qrdp_req_if req_if ();
  qrdp_res_if res_if ();

  int unsigned fail_cnt;
  int unsigned pending_rows;
  int unsigned rows_seen;

  // Percentages of cycles in which the sender holds back a request and the
  // receiver refuses a result.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned requests_sent;

  quantized_row_dot_product #(
    .MAX_COLS        (MAX_COLS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  qrdp_row_checker #(
    .MAX_COLS        (MAX_COLS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_mon_i  (req_if),
    .res_mon_i  (res_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_rows),
    .rows_o     (rows_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver decides at each falling edge whether it takes a result at the
  // next rising edge.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // The run is cut short if neither channel moves a request or a result for
  // too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb_top failed");
    $finish;
  end

  // Every task below is entered and left just after a falling edge. A request
  // stays valid from one call to the next, so back-to-back requests never drop
  // valid in between.
  task automatic send_request(logic rtype, logic [ACT_IDX_W-1:0] idx,
                              logic [ACT_VAL_W-1:0] val, logic [BYTE_W-1:0] wb,
                              logic [SCALE_W-1:0] rs);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.req_type    = rtype;
    req_if.act_index   = idx;
    req_if.act_value   = val;
    req_if.weight_byte = wb;
    req_if.row_scale   = rs;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Fields that an activation request does not use get random values, and the
  // other way round, so that every bit of every field toggles.
  task automatic write_act(logic [ACT_IDX_W-1:0] idx, logic [ACT_VAL_W-1:0] val);
    send_request(REQ_ACT, idx, val, BYTE_W'($urandom), $urandom);
  endtask

  task automatic send_weight(logic [BYTE_W-1:0] wb, logic [SCALE_W-1:0] rs);
    send_request(REQ_WEIGHT, ACT_IDX_W'($urandom), ACT_VAL_W'($urandom), wb, rs);
  endtask

  // Hold the sender back until every predicted row has come out, then give the
  // engine time to retire a byte that did not end a row.
  task automatic settle();
    req_if.valid = 1'b0;
    while (pending_rows != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  function automatic logic [ACT_VAL_W-1:0] pick_act_value();
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0: return 8'h80;
        1: return 8'h7F;
        2: return 8'h00;
        default: return 8'hFF;
      endcase
    end
    return ACT_VAL_W'($urandom);
  endfunction

  // Besides the int8 extremes, 0x88 makes both int4 nibbles zero and 0x08 pairs zero with -8.
  function automatic logic [BYTE_W-1:0] pick_weight_byte();
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(5))
        0: return 8'h80;
        1: return 8'h7F;
        2: return 8'h00;
        3: return 8'hFF;
        4: return 8'h88;
        default: return 8'h08;
      endcase
    end
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2: return ACT_SCALE_RST;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic                 fmt;
    logic [ROW_LEN_W-1:0] len;
    logic [SCALE_W-1:0]   scale;

    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_WEIGHT_FORMAT;
    cfg_data           = '0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_ACT;
    req_if.act_index   = '0;
    req_if.act_value   = '0;
    req_if.weight_byte = '0;
    req_if.row_scale   = '0;
    src_idle_pct       = 24;
    snk_idle_pct       = 57;
    requests_sent      = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. First a two-column int8 row with the signed extremes at
    // the reset activation scale.
    write_reg(CFG_WEIGHT_FORMAT, CFG_DATA_W'(FMT_INT8));
    write_reg(CFG_ROW_LENGTH, 2);
    write_act(0, 8'h80);
    write_act(1, 8'h7F);
    send_weight(8'h80, ACT_SCALE_RST);
    send_weight(8'h7F, ACT_SCALE_RST);

    // An int4 row of odd length: the high nibble of its last byte is ignored.
    // Both scales are at their maximum.
    settle();
    write_reg(CFG_WEIGHT_FORMAT, CFG_DATA_W'(FMT_INT4));
    write_reg(CFG_ROW_LENGTH, 3);
    write_reg(CFG_ACT_SCALE, '1);
    write_act(2, 8'hFF);
    send_weight(8'h0F, $urandom);
    send_weight(8'hF0, '1);

    // A row length of zero is treated as a single column; both scales zero.
    settle();
    write_reg(CFG_ROW_LENGTH, 0);
    write_reg(CFG_ACT_SCALE, 0);
    send_weight(8'hFF, '0);

    // Lowering the row length below the current column: the next byte supplies
    // one weight and closes the row. The oversized length is clamped first.
    settle();
    write_reg(CFG_WEIGHT_FORMAT, CFG_DATA_W'(FMT_INT8));
    write_reg(CFG_ROW_LENGTH, 13'h1FFF);
    write_reg(CFG_ACT_SCALE, ACT_SCALE_RST);
    write_act(3, 8'h81);
    repeat (3) send_weight(pick_weight_byte(), $urandom);
    settle();
    write_reg(CFG_ROW_LENGTH, 2);
    send_weight(pick_weight_byte(), $urandom);

    // The weight format switches twice in the middle of a row; each byte is
    // decoded with the format in force when it arrives.
    settle();
    write_reg(CFG_WEIGHT_FORMAT, CFG_DATA_W'(FMT_INT4));
    write_reg(CFG_ROW_LENGTH, 6);
    write_act(4, pick_act_value());
    write_act(5, pick_act_value());
    send_weight(pick_weight_byte(), $urandom);
    settle();
    write_reg(CFG_WEIGHT_FORMAT, CFG_DATA_W'(FMT_INT8));
    send_weight(pick_weight_byte(), $urandom);
    settle();
    write_reg(CFG_WEIGHT_FORMAT, CFG_DATA_W'(FMT_INT4));
    send_weight(pick_weight_byte(), $urandom);
    send_weight(pick_weight_byte(), $urandom);

    // The highest activation column.
    write_act(ACT_IDX_W'(MAX_COLS - 1), 8'h01);

    // One full-length int8 row at the extremes: every activation and weight is
    // -128 and both scales are at their maximum, which gives the largest dot
    // product and scaled value. It also fills the whole activation store, so
    // every later read hits a written column.
    settle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(CFG_WEIGHT_FORMAT, CFG_DATA_W'(FMT_INT8));
    write_reg(CFG_ROW_LENGTH, MAX_COLS);
    write_reg(CFG_ACT_SCALE, '1);
    for (int unsigned col = 0; col < MAX_COLS; col++) write_act(ACT_IDX_W'(col), 8'h80);
    for (int unsigned col = 0; col < MAX_COLS; col++) send_weight(8'h80, '1);

    // Random part. Any byte stream is a legal row, so rows end on their own;
    // activation requests land anywhere, also in the middle of a row. A phase
    // may stop mid-row, and the next register setting then acts on the row in
    // progress.
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph / 4)
        0: begin
          src_idle_pct = 24;
          snk_idle_pct = 57;
        end
        1: begin
          src_idle_pct = 57;
          snk_idle_pct = 24;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      fmt = (ph % 2 == 0) ? FMT_INT4 : FMT_INT8;
      if ($urandom_range(3) == 0) fmt = ~fmt;
      if (ph % 4 == 0) begin
        len = 1;
      end else if ($urandom_range(9) < 7) begin
        len = $urandom_range(2, 16);
      end else begin
        len = $urandom_range(17, 64);
      end
      if (ph == 2) begin
        scale = '0;
      end else if (ph == 6) begin
        scale = '1;
      end else begin
        scale = pick_scale();
      end
      write_reg(CFG_WEIGHT_FORMAT, CFG_DATA_W'(fmt));
      write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(len));
      write_reg(CFG_ACT_SCALE, scale);

      for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
        if ($urandom_range(99) < 20) begin
          write_act(ACT_IDX_W'($urandom_range(MAX_COLS - 1)), pick_act_value());
        end else begin
          send_weight(pick_weight_byte(), pick_scale());
        end
        // Now and then the sender stops until the engine has drained.
        if ($urandom_range(99) == 0) begin
          req_if.valid = 1'b0;
          while (pending_rows != 0) @(negedge clk_i);
        end
      end
    end

    settle();
    $display("Sent %0d requests and checked %0d row results: int8 and int4 rows,",
             requests_sent, rows_seen);
    $display("row lengths from zero to the clamped maximum, mid-row changes, extreme scales.");
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
